@@ src/mfm_enc_pkg.sv @@
package mfm_enc_pkg;

    localparam int unsigned LONGS_PER_SECTOR = 128;
    localparam int unsigned LONG_CNT_W       = 7;
    localparam int unsigned SEQ_W            = 6;
    localparam int unsigned IDX_W            = 10;

    localparam logic [15:0] FILL_WORD = 16'haaaa;
    localparam logic [15:0] SYNC_WORD = 16'h4489;
    localparam logic [31:0] EVEN_MASK = 32'h5555_5555;
    localparam logic [7:0]  HDR_FMT   = 8'hff;

    localparam logic [LONG_CNT_W-1:0] LAST_LONG = LONG_CNT_W'(LONGS_PER_SECTOR - 1);

    // Word slots of one item. Preamble slots match their sector-image index.
    localparam logic [SEQ_W-1:0] SEQ_PREAMBLE = 6'd0;
    localparam logic [SEQ_W-1:0] SEQ_DATA     = 6'd28;
    localparam logic [SEQ_W-1:0] SEQ_DATA_END = 6'd31;
    localparam logic [SEQ_W-1:0] SEQ_CKS_END  = 6'd35;

    localparam logic [IDX_W-1:0] ODD_DATA_BASE  = 10'd32;
    localparam logic [IDX_W-1:0] EVEN_DATA_BASE = 10'd288;

    typedef struct packed {
        logic [LONG_CNT_W-1:0] long_idx;
        logic [31:0]           hdr_odd;
        logic [31:0]           hdr_even;
        logic [31:0]           hdr_cks;
        logic [31:0]           data_odd;
        logic [31:0]           data_even;
        logic [31:0]           data_cks;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] word_index;
        logic [15:0]      mfm_word;
    } word_t;

endpackage

@@ src/mfm_enc_if.sv @@
interface mfm_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  track_number;
    logic [4:0]  sector_number;
    logic [31:0] data_long;

    modport source (output valid, output track_number, output sector_number,
                    output data_long, input ready);
    modport sink   (input valid, input track_number, input sector_number,
                    input data_long, output ready);
endinterface

interface mfm_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  word_index;
    logic [15:0] mfm_word;
    logic        run_end;

    modport source (output valid, output word_index, output mfm_word,
                    output run_end, input ready);
    modport sink   (input valid, input word_index, input mfm_word,
                    input run_end, output ready);
endinterface

@@ src/mfm_enc_word_sel.sv @@
module mfm_enc_word_sel (
    input  mfm_enc_pkg::item_t             item,
    input  logic [mfm_enc_pkg::SEQ_W-1:0]  seq,
    output mfm_enc_pkg::word_t             word
);

    logic [mfm_enc_pkg::IDX_W-1:0] long_ofs;
    logic [31:0]                   cks_odd;
    logic [31:0]                   hck_odd;

    // Checksum odd longs are shifted without masking.
    assign cks_odd  = item.data_cks >> 1;
    assign hck_odd  = item.hdr_cks >> 1;
    assign long_ofs = {2'b00, item.long_idx, seq[0]};

    always_comb
    begin
        word.word_index = mfm_enc_pkg::IDX_W'(seq);
        word.mfm_word   = mfm_enc_pkg::FILL_WORD;
        unique case (seq) inside
            [6'd0:6'd1]:   word.mfm_word = mfm_enc_pkg::FILL_WORD;
            [6'd2:6'd3]:   word.mfm_word = mfm_enc_pkg::SYNC_WORD;
            6'd4:          word.mfm_word = item.hdr_odd[31:16];
            6'd5:          word.mfm_word = item.hdr_odd[15:0];
            6'd6:          word.mfm_word = item.hdr_even[31:16];
            6'd7:          word.mfm_word = item.hdr_even[15:0];
            [6'd8:6'd23]:  word.mfm_word = mfm_enc_pkg::FILL_WORD;
            6'd24:         word.mfm_word = hck_odd[31:16];
            6'd25:         word.mfm_word = hck_odd[15:0];
            6'd26:         word.mfm_word = item.hdr_cks[31:16];
            6'd27:         word.mfm_word = item.hdr_cks[15:0];
            [6'd28:6'd29]:
            begin
                word.word_index = mfm_enc_pkg::ODD_DATA_BASE + long_ofs;
                word.mfm_word   = seq[0] ? item.data_odd[15:0] : item.data_odd[31:16];
            end
            [6'd30:6'd31]:
            begin
                word.word_index = mfm_enc_pkg::EVEN_DATA_BASE + long_ofs;
                word.mfm_word   = seq[0] ? item.data_even[15:0] : item.data_even[31:16];
            end
            6'd32:
            begin
                word.word_index = 10'd28;
                word.mfm_word   = cks_odd[31:16];
            end
            6'd33:
            begin
                word.word_index = 10'd29;
                word.mfm_word   = cks_odd[15:0];
            end
            6'd34:
            begin
                word.word_index = 10'd30;
                word.mfm_word   = item.data_cks[31:16];
            end
            6'd35:
            begin
                word.word_index = 10'd31;
                word.mfm_word   = item.data_cks[15:0];
            end
            default:
            begin
                word.word_index = mfm_enc_pkg::IDX_W'(seq);
                word.mfm_word   = mfm_enc_pkg::FILL_WORD;
            end
        endcase
    end

endmodule

@@ src/mfm_sector_encoder_top.sv @@
// The first word of a transaction's results passes through the item register and
// then the output word register; one word is delivered per cycle unless out_ch stalls.
// Each data long yields 4 output words, the first long of a sector 32 (preamble)
// and the last 8 (data checksum), all through the single output word register.
// Reset (rst_n low, asynchronous) clears the long count, the running checksum,
// all valid flags, and sets sectors_per_track to 11.
module mfm_sector_encoder_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [4:0]        cfg_wr_data,
    mfm_in_if.sink            in_ch,
    mfm_out_if.source         out_ch
);

    logic [4:0]                             spt_reg;
    logic [mfm_enc_pkg::LONG_CNT_W-1:0]     long_count_reg;
    logic [mfm_enc_pkg::LONG_CNT_W-1:0]     long_count_next;
    logic [31:0]                            cks_reg;
    logic [31:0]                            cks_next;

    mfm_enc_pkg::item_t                     item_reg;
    mfm_enc_pkg::item_t                     item_next;
    logic                                   item_valid_reg;
    logic [mfm_enc_pkg::SEQ_W-1:0]          seq_reg;
    logic [mfm_enc_pkg::SEQ_W-1:0]          seq_start;
    logic [mfm_enc_pkg::SEQ_W-1:0]          seq_end;

    logic                                   out_valid_reg;
    mfm_enc_pkg::word_t                     out_word_reg;
    logic                                   out_end_reg;
    mfm_enc_pkg::word_t                     sel_word;

    logic                                   out_load;
    logic                                   advance;
    logic                                   item_done;
    logic                                   in_fire;
    logic                                   first_long;
    logic [31:0]                            hdr_long;
    logic [7:0]                             gap_count;

    assign out_load  = !out_valid_reg || out_ch.ready;
    assign advance   = item_valid_reg && out_load;
    assign seq_end   = (item_reg.long_idx == mfm_enc_pkg::LAST_LONG)
                       ? mfm_enc_pkg::SEQ_CKS_END : mfm_enc_pkg::SEQ_DATA_END;
    assign item_done = seq_reg == seq_end;

    // A new transaction enters as soon as the held one hands over its last word.
    assign in_ch.ready = !item_valid_reg || (advance && item_done);
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign first_long = long_count_reg == '0;
    assign seq_start  = first_long ? mfm_enc_pkg::SEQ_PREAMBLE : mfm_enc_pkg::SEQ_DATA;
    assign gap_count  = {3'b000, spt_reg} - {3'b000, in_ch.sector_number};
    assign hdr_long   = {mfm_enc_pkg::HDR_FMT, in_ch.track_number,
                         {3'b000, in_ch.sector_number}, gap_count};

    always_comb
    begin
        item_next.long_idx  = long_count_reg;
        item_next.hdr_odd   = (hdr_long >> 1) & mfm_enc_pkg::EVEN_MASK;
        item_next.hdr_even  = hdr_long & mfm_enc_pkg::EVEN_MASK;
        item_next.hdr_cks   = item_next.hdr_odd ^ item_next.hdr_even;
        item_next.data_odd  = (in_ch.data_long >> 1) & mfm_enc_pkg::EVEN_MASK;
        item_next.data_even = in_ch.data_long & mfm_enc_pkg::EVEN_MASK;
        item_next.data_cks  = (first_long ? 32'h0 : cks_reg)
                              ^ item_next.data_odd ^ item_next.data_even;

        // The long count wraps naturally at the end of a sector.
        long_count_next = long_count_reg + 1'b1;
        cks_next        = item_next.data_cks;
    end

    mfm_enc_word_sel u_word_sel (
        .item (item_reg),
        .seq  (seq_reg),
        .word (sel_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg        <= 5'd11;
            long_count_reg <= '0;
            cks_reg        <= '0;
            item_valid_reg <= 1'b0;
            seq_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                spt_reg <= cfg_wr_data;
            end

            if (in_fire)
            begin
                long_count_reg <= long_count_next;
                cks_reg        <= cks_next;
                item_valid_reg <= 1'b1;
                seq_reg        <= seq_start;
            end
            else if (advance && item_done)
            begin
                item_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                seq_reg <= seq_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            out_word_reg <= sel_word;
            out_end_reg  <= item_done;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.word_index = out_word_reg.word_index;
    assign out_ch.mfm_word   = out_word_reg.mfm_word;
    assign out_ch.run_end    = out_end_reg;

endmodule
